/* rtl/lbs_pkg.sv */
// Shared types, constants and fixed-point helpers for the skinning core.
`timescale 1ns / 1ps
package lbs_pkg;

    localparam int MAX_BONES_DEF  = 64;
    localparam int ELEMS_PER_BONE = 12;
    localparam int QUEUE_DEPTH    = 4;
    localparam int TDATA_IN_W     = 208;
    localparam int TDATA_OUT_W    = 144;
    localparam int PADDR_W        = 3;
    localparam logic [PADDR_W-1:0] ADDR_BONE_COUNT = 3'd0;
    localparam logic CMD_LOAD = 1'b0;

    typedef enum logic [1:0] {
        K_NOP,
        K_LOAD,
        K_INFL,
        K_SKIP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [5:0]         bone;
        logic [3:0]         elem;
        logic signed [31:0] value;
        logic [16:0]        weight;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ADD,
        S_ROUND,
        S_WMUL,
        S_ACC,
        S_EMIT
    } t_state;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // round half up, drop 16 fraction bits, clamp to 32 bits
    function automatic logic signed [31:0] round16(input logic signed [63:0] s);
        logic signed [63:0] r;
        logic signed [63:0] q;
        r = sat_add64(s, 64'sd32768);
        q = r >>> 16;
        if (!((&q[63:31]) || (~|q[63:31]))) begin
            return q[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
        if (v == {1'b1, 31'd0}) begin
            return {1'b0, {31{1'b1}}};
        end
        return -v;
    endfunction

    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        if (v == {1'b1, 15'd0}) begin
            return {1'b0, {15{1'b1}}};
        end
        return -v;
    endfunction

endpackage

/* rtl/lbs_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lbs_front.sv */
// Front end: accepts requests, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module lbs_front #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [6:0]    i_bone_count,
    input  logic          i_valid,
    output logic          o_ready,
    input  lbs_pkg::t_item i_raw,
    input  logic          i_cmd,
    output logic          o_item_valid,
    output lbs_pkg::t_item o_item,
    input  logic          i_pop
);
    import lbs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item          r_q [QUEUE_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    t_item          w_cls;
    logic           w_push;
    logic           w_bone_ok;

    assign w_bone_ok = 32'(i_raw.bone) < MAX_BONES;

    always_comb begin
        w_cls = i_raw;
        if (i_cmd == CMD_LOAD) begin
            w_cls.kind = (w_bone_ok && (32'(i_raw.elem) < ELEMS_PER_BONE)) ? K_LOAD : K_NOP;
        end else begin
            w_cls.kind = (w_bone_ok && ({1'b0, i_raw.bone} < i_bone_count)) ? K_INFL : K_SKIP;
        end
    end

    assign o_ready      = r_cnt != (PW+1)'(QUEUE_DEPTH);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = r_cnt != '0;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(i_pop);
        end
    end
endmodule

/* rtl/lbs_back.sv */
// Back end: matrix store, transform and blend sequencer, result register.
`timescale 1ns / 1ps
module lbs_back #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_valid,
    input  lbs_pkg::t_item                    i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [lbs_pkg::TDATA_OUT_W-1:0]   o_data
);
    import lbs_pkg::*;

    localparam int DEPTH = MAX_BONES * ELEMS_PER_BONE;
    localparam int AW    = $clog2(DEPTH);

    t_state              r_state, n_state;
    t_item               r_item;
    logic [AW-1:0]       r_base;
    logic [1:0]          r_row, r_col;
    logic signed [63:0]  r_prod, r_sum, r_tw;
    logic signed [31:0]  r_t;
    logic signed [63:0]  r_acc [3];
    logic                r_out_valid;
    logic [TDATA_OUT_W-1:0] r_out;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_addr;
    logic [31:0]         ram_rdata;
    logic [AW-1:0]       w_wbase;
    logic signed [32:0]  w_op;
    logic signed [64:0]  w_mprod;
    logic signed [49:0]  w_wprod;
    logic                w_out_free;
    logic                w_emit;
    logic signed [31:0]  w_ex, w_ey, w_ez;

    lbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_item.value),
        .o_rdata (ram_rdata)
    );

    assign w_wbase    = AW'({i_item.bone, 3'b000}) + AW'({i_item.bone, 2'b00});
    assign w_out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.kind == K_INFL) begin
                        n_state = S_READ;
                    end else if (i_item.kind == K_SKIP && i_item.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = (r_col == 2'd3) ? S_ROUND : S_READ;
            S_ROUND: n_state = S_WMUL;
            S_WMUL:  n_state = S_ACC;
            S_ACC: begin
                if (r_row != 2'd2) begin
                    n_state = S_READ;
                end else begin
                    n_state = r_item.last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:  n_state = w_out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop    = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = r_base + AW'({r_row, r_col});
        w_emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_item_valid;
                if (i_item_valid && i_item.kind == K_LOAD) begin
                    ram_we   = 1'b1;
                    ram_addr = w_wbase + AW'(i_item.elem);
                end
            end
            S_READ:  ram_re = 1'b1;
            S_EMIT:  w_emit = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        case (r_col)
            2'd0:    w_op = 33'(r_item.px);
            2'd1:    w_op = 33'(r_item.py);
            2'd2:    w_op = 33'(r_item.pz);
            default: w_op = 33'sd65536;
        endcase
    end

    assign w_mprod = $signed(ram_rdata) * w_op;
    assign w_wprod = r_t * $signed({1'b0, r_item.weight});
    assign w_ex    = round16(r_acc[0]);
    assign w_ey    = neg_sat32(round16(r_acc[1]));
    assign w_ez    = round16(r_acc[2]);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_item;
                r_base <= w_wbase;
                r_row  <= 2'd0;
                r_col  <= 2'd0;
                r_sum  <= '0;
            end
            S_MUL:   r_prod <= w_mprod[63:0];
            S_ADD: begin
                r_sum <= sat_add64(r_sum, r_prod);
                r_col <= r_col + 2'd1;
            end
            S_ROUND: r_t  <= round16(r_sum);
            S_WMUL:  r_tw <= 64'(w_wprod);
            S_ACC: begin
                r_sum <= '0;
                r_col <= 2'd0;
                r_row <= r_row + 2'd1;
            end
            default: ;
        endcase
        if (w_emit) begin
            r_out <= {neg_sat16(r_item.ny), r_item.nz, r_item.nx, w_ey, w_ez, w_ex};
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc[0]    <= '0;
            r_acc[1]    <= '0;
            r_acc[2]    <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_acc[0]    <= '0;
                r_acc[1]    <= '0;
                r_acc[2]    <= '0;
            end else begin
                if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (r_state == S_ACC) begin
                    r_acc[r_row] <= sat_add64(r_acc[r_row], r_tw);
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

/* rtl/linear_blend_skinning_core.sv */
// Linear blend skinning core: top level with stream channels and register port.
//
// Slave stream: tuser is the command (0 = matrix element load, 1 = influence),
// tlast marks the last influence of a vertex, tdata carries the other fields.
// Master stream: one result per vertex, blended position and normal with the
// axes swapped to (x, z, -y).
// A small request queue decouples the front end from the sequencer, so the
// slave side keeps taking requests while the sequencer works or the master
// side stalls; tready drops only when the queue is full.
// A load or ignored influence is handled in the idle state; a result then waits in emit.
// An influence on a bone in use is taken from the queue, then per row it
// makes four reads of the single-port matrix RAM, each with one 32x33
// multiply and a saturating add, plus round, weight multiply and accumulate.
// A stalled master side holds the result register; the sequencer waits at its next result.
// Reset clears the queue, the sums, the result valid flag and bone_count; the
// matrix store is not cleared and must be loaded before use.
// bone_count sits at byte address 0 of the register port.
`timescale 1ns / 1ps
module linear_blend_skinning_core #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // bone_index, element_index, element_value, weight, pos_x, pos_y, pos_z,
    // normal_x, normal_y, normal_z
    input  logic [lbs_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // command
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_x, out_y, out_z, out_normal_x, out_normal_y, out_normal_z
    output logic [lbs_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbs_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import lbs_pkg::*;

    logic [6:0] r_bone_count;
    t_item      w_raw, w_item;
    logic       w_item_valid, w_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BONE_COUNT) ? {25'd0, r_bone_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count <= '0;
        end else if (psel && penable && pwrite && paddr == ADDR_BONE_COUNT) begin
            r_bone_count <= pwdata[6:0];
        end
    end

    always_comb begin
        w_raw.kind   = K_NOP;
        w_raw.bone   = s_axis_tdata[5:0];
        w_raw.elem   = s_axis_tdata[9:6];
        w_raw.value  = s_axis_tdata[41:10];
        w_raw.weight = s_axis_tdata[58:42];
        w_raw.px     = s_axis_tdata[90:59];
        w_raw.py     = s_axis_tdata[122:91];
        w_raw.pz     = s_axis_tdata[154:123];
        w_raw.nx     = s_axis_tdata[170:155];
        w_raw.ny     = s_axis_tdata[186:171];
        w_raw.nz     = s_axis_tdata[202:187];
        w_raw.last   = s_axis_tlast;
    end

    lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bone_count (r_bone_count),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_raw        (w_raw),
        .i_cmd        (s_axis_tuser),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    lbs_back #(.MAX_BONES(MAX_BONES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );
endmodule

/* dv/linear_blend_skinning_core_tb.sv */
// Testbench for the skinning core: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps
module linear_blend_skinning_core_tb;
    import lbs_pkg::*;

    typedef struct {
        bit        cmd;
        bit [5:0]  bone;
        bit [3:0]  elem;
        bit [31:0] val;
        bit [16:0] wgt;
        bit [31:0] px, py, pz;
        bit [15:0] nx, ny, nz;
        bit        last;
    } t_req;

    typedef struct {
        bit [31:0] x, y, z;
        bit [15:0] nx, ny, nz;
    } t_vtx;

    typedef struct {
        bit   is_cfg;
        int   cfg_val;
        t_req r;
        bit   typed;
        t_vtx e;
    } t_row;

    logic                   i_clk = 0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // bone_index, element_index, element_value, weight, pos_x, pos_y, pos_z,
    // normal_x, normal_y, normal_z
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    // command
    logic                   s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // out_x, out_y, out_z, out_normal_x, out_normal_y, out_normal_z
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   psel, penable, pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    linear_blend_skinning_core uut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    bit [31:0] mat_shadow [0:MAX_BONES_DEF*ELEMS_PER_BONE-1];
    bit [11:0] elem_written [0:MAX_BONES_DEF-1];
    longint    blend_sum [0:2];
    int        active_bones;

    t_vtx vtx_expected[$];
    int   errors, n_items, n_loads, n_vertices, cycles;
    int   burst_left;

    function automatic longint sadd(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        return s[63:0];
    endfunction

    function automatic longint drop_frac(longint s);
        longint q;
        q = sadd(s, 32768) >>> 16;
        if (q > 64'sd2147483647) return 64'sd2147483647;
        if (q < -64'sd2147483648) return -64'sd2147483648;
        return q;
    endfunction

    function automatic bit skin_step(t_req r, output t_vtx o);
        longint p[3], s, t, y;
        int b;
        b = r.bone * ELEMS_PER_BONE;
        o = '{default: 0};
        if (r.cmd == CMD_LOAD) begin
            if (r.elem < ELEMS_PER_BONE) begin
                mat_shadow[b + r.elem] = r.val;
                elem_written[r.bone][r.elem] = 1;
            end
            return 0;
        end
        if (r.bone < active_bones) begin
            p[0] = longint'($signed(r.px));
            p[1] = longint'($signed(r.py));
            p[2] = longint'($signed(r.pz));
            for (int k = 0; k < 3; k++) begin
                s = longint'($signed(mat_shadow[b+4*k])) * p[0];
                s = sadd(s, longint'($signed(mat_shadow[b+4*k+1])) * p[1]);
                s = sadd(s, longint'($signed(mat_shadow[b+4*k+2])) * p[2]);
                s = sadd(s, longint'($signed(mat_shadow[b+4*k+3])) * 65536);
                t = drop_frac(s);
                blend_sum[k] = sadd(blend_sum[k], t * longint'(r.wgt));
            end
        end
        if (!r.last) return 0;
        y = -drop_frac(blend_sum[1]);
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        o.x  = drop_frac(blend_sum[0]);
        o.y  = drop_frac(blend_sum[2]);
        o.z  = y;
        o.nx = r.nx;
        o.ny = r.nz;
        o.nz = (r.ny == 16'h8000) ? 16'h7fff : -r.ny;
        blend_sum = '{0, 0, 0};
        return 1;
    endfunction

    task automatic send_request(t_req r, bit typed, t_vtx e);
        t_vtx o;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tuser  <= r.cmd;
        s_axis_tlast  <= r.last;
        s_axis_tdata  <= {5'd0, r.nz, r.ny, r.nx, r.pz, r.py, r.px, r.wgt, r.val,
                          r.elem, r.bone};
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
        if (r.cmd == CMD_LOAD) n_loads++;
        if (skin_step(r, o)) vtx_expected.insert(vtx_expected.size(), typed ? e : o);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 0;
        while (vtx_expected.size() != 0) @(posedge i_clk);
        // influences without a result may still be in flight
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_bone_count(int v);
        drain_results();
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= ADDR_BONE_COUNT;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        active_bones = v;
    endtask

    function automatic bit [31:0] rand_q16();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 32'h3ffff) - 32'h20000;
    endfunction

    function automatic t_req rand_request();
        t_req r;
        int tries;
        r.val  = rand_q16();
        r.px   = rand_q16();
        r.py   = rand_q16();
        r.pz   = rand_q16();
        r.nx   = $urandom;
        r.ny   = $urandom;
        r.nz   = $urandom;
        r.elem = $urandom_range(0, 15);
        r.last = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 3))
            0: r.wgt = 17'h10000;
            1: r.wgt = $urandom;
            default: r.wgt = $urandom_range(0, 65535);
        endcase
        r.cmd  = !CMD_LOAD;
        r.bone = $urandom_range(0, 63);
        if ($urandom_range(0, 9) < 2) begin
            r.cmd = CMD_LOAD;
        end else if ($urandom_range(0, 9) < 8 || active_bones >= MAX_BONES_DEF) begin
            // pick a bone in use whose matrix is fully loaded
            tries = 0;
            while (!(r.bone < active_bones && elem_written[r.bone] == 12'hfff) && tries < 16) begin
                r.bone = $urandom_range(0, 63);
                tries++;
            end
            if (tries == 16) r.cmd = CMD_LOAD;
        end else begin
            r.bone = $urandom_range(active_bones, 63);
        end
        return r;
    endfunction

    // receiver: stall pattern rotates through always ready, half ready and quarter ready
    always @(posedge i_clk) begin
        t_vtx a, e;
        int mode;
        cycles++;
        mode = (cycles / 200) % 3;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'($urandom_range(0, 1))
                                                             : ($urandom_range(0, 3) == 0);
            if (m_axis_tvalid && m_axis_tready) begin
                {a.nz, a.ny, a.nx, a.z, a.y, a.x} = m_axis_tdata;
                if (vtx_expected.size() == 0) begin
                    $error("vertex result with none expected");
                    errors++;
                end else begin
                    e = vtx_expected.pop_front();
                    n_vertices++;
                    if (a.x != e.x) begin $error("out_x exp %h got %h", e.x, a.x); errors++; end
                    if (a.y != e.y) begin $error("out_y exp %h got %h", e.y, a.y); errors++; end
                    if (a.z != e.z) begin $error("out_z exp %h got %h", e.z, a.z); errors++; end
                    if (a.nx != e.nx) begin
                        $error("out_normal_x exp %h got %h", e.nx, a.nx); errors++;
                    end
                    if (a.ny != e.ny) begin
                        $error("out_normal_y exp %h got %h", e.ny, a.ny); errors++;
                    end
                    if (a.nz != e.nz) begin
                        $error("out_normal_z exp %h got %h", e.nz, a.nz); errors++;
                    end
                end
            end
        end
        if (cycles > 600000) begin
            $display("timeout with %0d results outstanding", vtx_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    t_row  dir_rows[$];
    int    phase_counts[5] = '{64, 0, 37, 64, 1};

    task automatic add_row(bit cfg, int cv, bit cmd, int bone, int elem, bit [31:0] val,
                           bit [16:0] w, bit [31:0] p, bit [15:0] n, bit last);
        t_row d;
        d = '{default: 0};
        d.is_cfg = cfg;
        d.cfg_val = cv;
        d.r = '{cmd, bone, elem, val, w, p, ~p, p ^ 32'h5555_5555, n, ~n, n ^ 16'h00ff, last};
        dir_rows.insert(dir_rows.size(), d);
    endtask

    initial begin
        t_req r;
        t_vtx none;
        t_row d;
        none = '{default: 0};
        i_rst_n = 0; s_axis_tvalid <= 0; s_axis_tdata <= '0; s_axis_tuser <= 0;
        s_axis_tlast <= 0; psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0;
        pwdata <= '0;
        blend_sum = '{0, 0, 0};
        foreach (elem_written[i]) elem_written[i] = 0;
        active_bones = 0;

        // after reset every bone is out of use: zero position, swapped normals
        d = '{default: 0};
        d.r = '{!CMD_LOAD, 0, 0, 0, 17'h10000, 1, 2, 3, 16'h7fff, 16'h8000, 16'h8000, 1};
        d.typed = 1;
        d.e = '{0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff};
        dir_rows.insert(dir_rows.size(), d);
        add_row(0, 0, CMD_LOAD, 63, 12, 32'hdead_beef, 0, 0, 0, 1);   // outside store
        add_row(0, 0, CMD_LOAD, 63, 15, 32'h1234_5678, 0, 0, 0, 0);
        for (int k = 0; k < 12; k++)
            add_row(0, 0, CMD_LOAD, 0, k,
                    (k < 4) ? ((k % 2) ? 32'h8000_0000 : 32'h7fff_ffff) :
                    (k < 8) ? ((k == 5) ? 32'h1_0000 : 32'hffff_0000) : 32'h8000_0000,
                    0, 0, 0, 0);
        add_row(1, 64, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, !CMD_LOAD, 0, 0, 0, 17'h10000, 32'h7fff_ffff, 16'h7fff, 0);
        add_row(0, 0, !CMD_LOAD, 0, 0, 0, 17'h1ffff, 32'h8000_0000, 16'h8000, 0);
        add_row(0, 0, !CMD_LOAD, 0, 0, 0, 17'h0, 32'h0001_0000, 16'h0001, 1);
        add_row(0, 0, !CMD_LOAD, 0, 0, 0, 17'h8000, 32'hffff_ffff, 16'hffff, 1);
        add_row(1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, !CMD_LOAD, 40, 0, 0, 17'h1, 32'h0000_0001, 16'h4000, 1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) write_bone_count(dir_rows[i].cfg_val);
            else send_request(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
        end

        // load every matrix, then random traffic under several bone counts
        for (int b = 0; b < MAX_BONES_DEF; b++)
            for (int k = 0; k < ELEMS_PER_BONE; k++) begin
                r = rand_request();
                r.cmd = CMD_LOAD; r.bone = b; r.elem = k;
                send_request(r, 0, none);
            end
        foreach (phase_counts[ph]) begin
            write_bone_count(phase_counts[ph]);
            for (int i = 0; i < 156; i++) send_request(rand_request(), 0, none);
        end
        drain_results();

        $display("%0d requests sent (%0d matrix loads), %0d vertices checked,",
                 n_items, n_loads, n_vertices);
        $display("bone counts 0, 1, 37 and 64 with bursty input and stalled output");
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

/* files.f */
rtl/lbs_pkg.sv
rtl/lbs_ram.sv
rtl/lbs_front.sv
rtl/lbs_back.sv
rtl/linear_blend_skinning_core.sv
dv/linear_blend_skinning_core_tb.sv
